// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Compile with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define APQMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define APQMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define APQMS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define APQMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/apqms_pkg.sv -----
package apqms_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int VAL_W         = 32;
    localparam int PRI_W         = 6;
    localparam int OCC_W         = 11;
    localparam int STAT_W        = 2;
    localparam int MOD_BASE      = 17;

    // input word kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0]        val;
        logic signed [PRI_W-1:0] prio;
    } apqms_entry_t;

    typedef struct packed {
        logic                    done;
        logic signed [PRI_W-1:0] prio;
    } apqms_mod_res_t;

endpackage

// ----- rtl/apqms_if.sv -----
interface apqms_in_if
    import apqms_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

interface apqms_out_if
    import apqms_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic [STAT_W-1:0]       status;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, out_value, status, occupancy, input ready);
    modport sink   (input valid, out_value, status, occupancy, output ready);
endinterface

// ----- rtl/apqms_mod17.sv -----
// Truncating remainder by 17 on one shared compare-subtract step.
// Add the magnitude bytes (256 is 1 mod 17), fold the carry byte back in,
// then take off 8, 4, 2 and 1 times the base; the sign follows the dividend.
module apqms_mod17
    import apqms_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] value,
    output apqms_mod_res_t          res
);

    localparam int REM_W = $clog2(MOD_BASE);
    localparam int ACC_W = 10;

    // sequencer steps
    localparam logic [2:0] STEP_SUM  = 3'd0;
    localparam logic [2:0] STEP_FOLD = 3'd1;
    localparam logic [2:0] STEP_SUB8 = 3'd2;
    localparam logic [2:0] STEP_SUB4 = 3'd3;
    localparam logic [2:0] STEP_SUB2 = 3'd4;
    localparam logic [2:0] STEP_SUB1 = 3'd5;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2:0]       step_reg, step_next;
    logic [VAL_W-1:0] mag_reg, mag_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] sub_amt;

    always_comb
    begin
        unique case (step_reg)
            STEP_SUB8: sub_amt = ACC_W'(MOD_BASE * 8);
            STEP_SUB4: sub_amt = ACC_W'(MOD_BASE * 4);
            STEP_SUB2: sub_amt = ACC_W'(MOD_BASE * 2);
            default:   sub_amt = ACC_W'(MOD_BASE);
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_SUM;
            neg_next  = value[VAL_W-1];
            mag_next  = value[VAL_W-1] ? (~value + 1'b1) : value;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            unique case (step_reg)
                STEP_SUM:
                begin
                    acc_next = ACC_W'(mag_reg[7:0]) + ACC_W'(mag_reg[15:8])
                             + ACC_W'(mag_reg[23:16]) + ACC_W'(mag_reg[31:24]);
                end
                STEP_FOLD:
                begin
                    acc_next = ACC_W'(acc_reg[7:0]) + ACC_W'(acc_reg[ACC_W-1:8]);
                end
                default:
                begin
                    // drop one multiple of the base if it fits
                    if (acc_reg >= sub_amt)
                    begin
                        acc_next = acc_reg - sub_amt;
                    end
                end
            endcase
            if (step_reg == STEP_SUB1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
    end

    assign res.done = done_reg;
    assign res.prio = neg_reg ? -$signed(PRI_W'(acc_reg[REM_W-1:0]))
                              : $signed(PRI_W'(acc_reg[REM_W-1:0]));

endmodule

// ----- rtl/apqms_mem.sv -----
// Entry store: one write port, one read port with registered data.
module apqms_mem
    import apqms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  apqms_entry_t  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output apqms_entry_t  rd_data
);

    apqms_entry_t mem [DEPTH];
    apqms_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/array_priority_queue_min_scan.sv -----
// Channel | Dir | Fields                          | Word
// --------+-----+---------------------------------+------------------------------
// cmd     | in  | kind, value                     | enqueue value / dequeue min
// res     | out | out_value, status, occupancy    | one result per command word
//
// Enqueue: waits on the modulo-17 unit (byte fold, carry fold, then four
//   compare-subtract steps on one shared unit), then appends at the tail.
// Dequeue: the single memory read port first scans every held entry, then
//   streams the entries above the minimum down one slot.
// Errors (overflow, empty dequeue) go straight to the finish state, with no memory access.
// Reset clears the fill count, the sequencer state and the valid flags only; no clearing pass.
// A result waits in the output register while the next command is taken;
//   a command finishing while that register is still full holds until it drains.
module array_priority_queue_min_scan
    import apqms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    apqms_in_if.sink          cmd,
    apqms_out_if.source       res
);

    `include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic signed [PRI_W-1:0] PRI_INIT = {1'b0, {(PRI_W-1){1'b1}}};

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOD    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SETUP  = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           rd_addr_reg, rd_addr_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    logic signed [PRI_W-1:0] best_pri_reg, best_pri_next;
    logic [VAL_W-1:0]        best_val_reg, best_val_next;
    logic [VAL_W-1:0]        hold_val_reg, hold_val_next;
    logic [VAL_W-1:0]        pend_val_reg, pend_val_next;
    logic [STAT_W-1:0]       pend_stat_reg, pend_stat_next;
    logic                    res_valid_reg, res_valid_next;
    logic [VAL_W-1:0]        res_val_reg, res_val_next;
    logic [STAT_W-1:0]       res_stat_reg, res_stat_next;
    logic [OCC_W-1:0]        res_occ_reg, res_occ_next;

    logic                    accept;
    logic                    issue;
    logic                    mod_start;
    apqms_mod_res_t          mod_res;
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    apqms_entry_t            mem_wr_data;
    apqms_entry_t            mem_rd_data;
    logic [CW-1:0]           count_last;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign count_last = count_reg - CW'(1);
    assign issue      = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT))
                        && (rd_addr_reg < count_reg);

    apqms_mod17 u_mod17
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (cmd.value),
        .res   (mod_res)
    );

    apqms_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr_reg[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        rd_vld_next    = issue;
        rd_idx_next    = rd_addr_reg[AW-1:0];
        best_idx_next  = best_idx_reg;
        best_pri_next  = best_pri_reg;
        best_val_next  = best_val_reg;
        hold_val_next  = hold_val_reg;
        pend_val_next  = pend_val_reg;
        pend_stat_next = pend_stat_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_val_next   = res_val_reg;
        res_stat_next  = res_stat_reg;
        res_occ_next   = res_occ_reg;
        mod_start      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = count_reg[AW-1:0];
        mem_wr_data    = '{val: hold_val_reg, prio: mod_res.prio};
        if (issue)
        begin
            rd_addr_next = rd_addr_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_val_next = '0;
                    if (cmd.kind == KIND_ENQ)
                    begin
                        if (count_reg >= CNT_FULL)
                        begin
                            pend_stat_next = STAT_OVERFLOW;
                            state_next     = ST_FINISH;
                        end
                        else
                        begin
                            hold_val_next = cmd.value;
                            mod_start     = 1'b1;
                            state_next    = ST_MOD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pend_stat_next = STAT_EMPTY;
                            state_next     = ST_FINISH;
                        end
                        else
                        begin
                            rd_addr_next  = '0;
                            best_pri_next = PRI_INIT;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_MOD:
            begin
                // append at the tail once the priority is known
                if (mod_res.done)
                begin
                    mem_wr_en      = 1'b1;
                    count_next     = count_reg + CW'(1);
                    pend_stat_next = STAT_OK;
                    state_next     = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                // later entries win ties
                if (rd_vld_reg)
                begin
                    if (mem_rd_data.prio <= best_pri_reg)
                    begin
                        best_pri_next = mem_rd_data.prio;
                        best_idx_next = rd_idx_reg;
                        best_val_next = mem_rd_data.val;
                    end
                    if (CW'(rd_idx_reg) == count_last)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                rd_addr_next = CW'(best_idx_reg) + CW'(1);
                state_next   = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // move each later entry down one slot
                if (rd_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = rd_idx_reg - AW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (!issue && !rd_vld_reg)
                begin
                    count_next     = count_last;
                    pend_val_next  = best_val_reg;
                    pend_stat_next = STAT_OK;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_val_next   = pend_val_reg;
                    res_stat_next  = pend_stat_reg;
                    res_occ_next   = OCC_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_pri_reg  <= best_pri_next;
        best_val_reg  <= best_val_next;
        hold_val_reg  <= hold_val_next;
        pend_val_reg  <= pend_val_next;
        pend_stat_reg <= pend_stat_next;
        res_val_reg   <= res_val_next;
        res_stat_reg  <= res_stat_next;
        res_occ_reg   <= res_occ_next;
    end

    assign res.valid     = res_valid_reg;
    assign res.out_value = res_val_reg;
    assign res.status    = res_stat_reg;
    assign res.occupancy = res_occ_reg;

    `APQMS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `APQMS_ASSERT_NOW(a_mod_in_state, clk, rst_n, mod_res.done, state_reg == ST_MOD)
    `APQMS_ASSERT_NOW(a_shift_above_best, clk, rst_n, (state_reg == ST_SHIFT) && rd_vld_reg, rd_idx_reg > best_idx_reg)
    `APQMS_ASSERT_NOW(a_scan_in_range, clk, rst_n, (state_reg == ST_SCAN) && rd_vld_reg, CW'(rd_idx_reg) < count_reg)
    `APQMS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, !cmd.ready)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import apqms_pkg::*;

    // Run at the default depth; the cost of a dequeue grows with the fill,
    // so the fill stays within a few dozen entries most of the time.
    localparam int QDEPTH = DEPTH_DEFAULT;

    // Random part length, on top of the directed words.
    localparam int RANDOM_WORDS = 258;

    // Command word as queued for the driver. drain_first holds the word back
    // until every result already owed has come out of the block.
    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic                    drain_first;
    } cmd_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic [STAT_W-1:0]       status;
        logic [OCC_W-1:0]        occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;

    apqms_in_if  cmd_if ();
    apqms_out_if res_if ();

    array_priority_queue_min_scan #(
        .DEPTH(QDEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if),
        .res  (res_if)
    );

    // Mirror of the queue contents: values and their signed mod-17 priorities,
    // in insertion order.
    logic signed [VAL_W-1:0] held_val [QDEPTH];
    int                      held_pri [QDEPTH];
    int                      held_count;

    cmd_word_t     pending_words[$];
    queue_result_t expected_results[$];
    int            fail_count;

    cmd_word_t     next_word;
    queue_result_t want_res;
    int            send_gap;
    int            send_calm;
    int            recv_gap;
    int            recv_calm;

    // Apply one command word to the mirror and return the result word it owes.
    function automatic queue_result_t step_queue(input logic kind,
                                                 input logic signed [VAL_W-1:0] value);
        queue_result_t r;
        int            pick;
        int            low_pri;
        r = '0;
        if (kind == KIND_ENQ)
        begin
            if (held_count >= QDEPTH)
            begin
                r.status = STAT_OVERFLOW;
            end
            else
            begin
                held_val[held_count] = value;
                // SV remainder truncates toward zero, so this spans -16..16
                held_pri[held_count] = int'(value) % MOD_BASE;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            r.status = STAT_EMPTY;
        end
        else
        begin
            pick    = 0;
            low_pri = held_pri[0];
            // <= so that a tie moves the pick to the later entry
            for (int i = 0; i < held_count; i++)
            begin
                if (held_pri[i] <= low_pri)
                begin
                    low_pri = held_pri[i];
                    pick    = i;
                end
            end
            r.out_value = held_val[pick];
            for (int i = pick; i + 1 < held_count; i++)
            begin
                held_val[i] = held_val[i + 1];
                held_pri[i] = held_pri[i + 1];
            end
            held_count--;
        end
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    // Idle length after a word: mostly none or short, a few long. A calm stretch
    // forces back-to-back traffic for a while.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(15, 40);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 94)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Value mix: full-range random, small values that collide in priority,
    // multiples of 17 and their neighbors, and both ends of the signed range.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return int'($urandom_range(0, 80)) - 40;
            7:             return 17 * (int'($urandom_range(0, 20)) - 10)
                                  + int'($urandom_range(0, 2)) - 1;
            8:             return 32'h8000_0000 + $urandom_range(0, 40);
            default:       return 32'h7FFF_FFFF - $urandom_range(0, 40);
        endcase
    endfunction

    function automatic cmd_word_t make_word(input logic kind,
                                            input logic signed [VAL_W-1:0] value,
                                            input logic drain_first);
        cmd_word_t w;
        w.kind        = kind;
        w.value       = value;
        w.drain_first = drain_first;
        return w;
    endfunction

    // Clock: 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Driver: present the next queued command word; hold it until taken.
    // Predict the result at the edge where the word is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.kind  <= KIND_ENQ;
            cmd_if.value <= '0;
            send_gap  = 0;
            send_calm = 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                expected_results.push_back(step_queue(cmd_if.kind, cmd_if.value));
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && expected_results.size() != 0))
                begin
                    next_word = pending_words.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.kind  <= next_word.kind;
                    cmd_if.value <= next_word.value;
                    send_gap = pick_gap(send_calm);
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take result words, compare against the oldest prediction,
    // then stall ready for a random while.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_gap  = 0;
            recv_calm = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word: out_value %0d status %0d occupancy %0d",
                           res_if.out_value, res_if.status, res_if.occupancy);
                    fail_count++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (res_if.out_value !== want_res.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d",
                               want_res.out_value, res_if.out_value);
                        fail_count++;
                    end
                    if (res_if.status !== want_res.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want_res.status, res_if.status);
                        fail_count++;
                    end
                    if (res_if.occupancy !== want_res.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want_res.occupancy, res_if.occupancy);
                        fail_count++;
                    end
                end
                recv_gap = pick_gap(recv_calm);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int   burst_len;
        int   mode;
        int   added;
        logic kind;

        // Drive every input to a known level from time zero.
        rst_n        = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.kind  = KIND_ENQ;
        cmd_if.value = '0;
        res_if.ready = 1'b0;
        held_count   = 0;
        fail_count   = 0;

        // Directed: dequeue on an empty queue first.
        pending_words.push_back(make_word(KIND_DEQ, 32'sd0, 1'b0));
        // Load range extremes, signs on both sides of zero, multiples of 17
        // and values sharing a priority (5 and 22).
        pending_words.push_back(make_word(KIND_ENQ, 32'sh7FFF_FFFF, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sh8000_0000, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd0, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, -32'sd1, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd16, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, -32'sd16, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd17, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, -32'sd17, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd33, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, -32'sd33, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd5, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd22, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, -32'sd50, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sh5555_5555, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'shAAAA_AAAA, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd1, 1'b0));
        pending_words.push_back(make_word(KIND_ENQ, 32'sd7, 1'b0));
        // Pull a few back out; the value field on a dequeue is don't-care.
        pending_words.push_back(make_word(KIND_DEQ, 32'shFFFF_FFFF, 1'b0));
        pending_words.push_back(make_word(KIND_DEQ, 32'sd0, 1'b0));
        pending_words.push_back(make_word(KIND_DEQ, 32'sh1234_5678, 1'b0));
        pending_words.push_back(make_word(KIND_DEQ, 32'sd0, 1'b0));
        pending_words.push_back(make_word(KIND_DEQ, 32'sd0, 1'b0));

        // Random: mostly enqueue bursts and dequeue bursts in random order, long enough
        // to drain the queue now and then; the rest mixed noise. The first
        // random word waits for the directed results to drain.
        added = 0;
        while (added < RANDOM_WORDS)
        begin
            mode      = $urandom_range(0, 9);
            burst_len = $urandom_range(1, 24);
            for (int i = 0; i < burst_len; i++)
            begin
                if (mode < 4)
                    kind = KIND_ENQ;
                else if (mode < 8)
                    kind = KIND_DEQ;
                else
                    kind = $urandom_range(0, 1);
                pending_words.push_back(make_word(kind, pick_value(),
                                        added == 0 || $urandom_range(0, 39) == 0));
                added++;
            end
        end

        // Hold reset low at the start, then release it for good.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every result to come back, then
        // give the block time to show any stray result word.
        while (pending_words.size() != 0 || cmd_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
